// ===== rtl/bll_pkg.sv =====
// Shared constants for the bounded linked list engine.
// Command codes, status codes and field widths; no dependencies.
`timescale 1ns / 1ps

package bll_pkg;

	localparam int NODES_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int CMD_W     = 4;
	localparam int ST_W      = 3;

	localparam logic [CMD_W-1:0] CMD_PUSH     = 4'd0;
	localparam logic [CMD_W-1:0] CMD_POP      = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_MOVE     = 4'd5;
	localparam logic [CMD_W-1:0] CMD_EXCHANGE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_FIND     = 4'd7;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd8;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD      = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

// ===== rtl/bounded_linked_list_engine.sv =====
// Top level of the bounded linked list engine: stream ports, field packing,
// sequencer and memories. Uses bll_pkg, bll_ctrl and bll_mem.
//
// Channel  Dir  Handshake                Payload
// s_axis   in   s_axis_tvalid/tready     tuser: cmd; tdata: key_in, node_a, node_b
// m_axis   out  m_axis_tvalid/tready     tuser: status; tdata: key_out, node_out, count
//
// One command is in work at a time; the next is taken once its result is registered.
// Push, clear and errors found at dispatch finish in the dispatch state; other commands go on
// through further states, and find visits one link per step (up to NODES), each step paced by
// the single registered read port. Reset is asynchronous and empties the list at once; a stalled
// result holds the next command.
`timescale 1ns / 1ps

module bounded_linked_list_engine #(
	parameter int NODES = bll_pkg::NODES_DEF,
	localparam int HW = $clog2(NODES + 2),
	localparam int CW = $clog2(NODES + 1),
	localparam int IN_DW = ((bll_pkg::KEY_W + 2 * HW + 7) / 8) * 8,
	localparam int OUT_DW = ((bll_pkg::KEY_W + HW + CW + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_DW-1:0]          s_axis_tdata,  // key_in, node_a, node_b
	input  logic [bll_pkg::CMD_W-1:0] s_axis_tuser,  // cmd
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_DW-1:0]         m_axis_tdata,  // key_out, node_out, count
	output logic [bll_pkg::ST_W-1:0]  m_axis_tuser   // status
);
	import bll_pkg::*;

	localparam int SW = $clog2(NODES);

	logic [KEY_W-1:0] key_out, rd_key, kw_data;
	logic [HW-1:0]    node_out, rd_link, lw_data;
	logic [CW-1:0]    count;
	logic [SW-1:0]    rd_addr, lw_addr, kw_addr;
	logic             lw_en, kw_en;

	bll_ctrl #(.NODES(NODES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (s_axis_tuser),
		.key_in    (s_axis_tdata[KEY_W-1:0]),
		.node_a    (s_axis_tdata[KEY_W+HW-1:KEY_W]),
		.node_b    (s_axis_tdata[KEY_W+2*HW-1:KEY_W+HW]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (m_axis_tuser),
		.key_out   (key_out),
		.node_out  (node_out),
		.count     (count),
		.rd_addr   (rd_addr),
		.rd_link   (rd_link),
		.rd_key    (rd_key),
		.lw_en     (lw_en),
		.lw_addr   (lw_addr),
		.lw_data   (lw_data),
		.kw_en     (kw_en),
		.kw_addr   (kw_addr),
		.kw_data   (kw_data)
	);

	bll_mem #(.NODES(NODES)) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_link (rd_link),
		.rd_key  (rd_key),
		.lw_en   (lw_en),
		.lw_addr (lw_addr),
		.lw_data (lw_data),
		.kw_en   (kw_en),
		.kw_addr (kw_addr),
		.kw_data (kw_data)
	);

	assign m_axis_tdata = OUT_DW'({count, node_out, key_out});

endmodule

// ===== rtl/bll_mem.sv =====
// Link and key memories of the linked list engine, one registered read port each.
// Uses bll_pkg for the key width.
`timescale 1ns / 1ps

module bll_mem #(
	parameter int NODES = bll_pkg::NODES_DEF,
	localparam int HW = $clog2(NODES + 2),
	localparam int SW = $clog2(NODES)
) (
	input  logic                     clk,
	input  logic [SW-1:0]            rd_addr,
	output logic [HW-1:0]            rd_link,
	output logic [bll_pkg::KEY_W-1:0] rd_key,
	input  logic                     lw_en,
	input  logic [SW-1:0]            lw_addr,
	input  logic [HW-1:0]            lw_data,
	input  logic                     kw_en,
	input  logic [SW-1:0]            kw_addr,
	input  logic [bll_pkg::KEY_W-1:0] kw_data
);
	import bll_pkg::*;

	logic [HW-1:0]    link_mem [NODES];
	logic [KEY_W-1:0] key_mem [NODES];

	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		rd_link <= link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (kw_en) begin
			key_mem[kw_addr] <= kw_data;
		end
		rd_key <= key_mem[rd_addr];
	end

endmodule

// ===== rtl/bll_ctrl.sv =====
// Command sequencer of the linked list engine: head, rear, count and slot flags,
// memory access sequencing and the result register. Uses bll_pkg.
`timescale 1ns / 1ps

module bll_ctrl #(
	parameter int NODES = bll_pkg::NODES_DEF,
	localparam int HW = $clog2(NODES + 2),
	localparam int SW = $clog2(NODES),
	localparam int CW = $clog2(NODES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bll_pkg::CMD_W-1:0] cmd,
	input  logic [bll_pkg::KEY_W-1:0] key_in,
	input  logic [HW-1:0]             node_a,
	input  logic [HW-1:0]             node_b,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bll_pkg::ST_W-1:0]  status,
	output logic [bll_pkg::KEY_W-1:0] key_out,
	output logic [HW-1:0]             node_out,
	output logic [CW-1:0]             count,
	output logic [SW-1:0]             rd_addr,
	input  logic [HW-1:0]             rd_link,
	input  logic [bll_pkg::KEY_W-1:0] rd_key,
	output logic                      lw_en,
	output logic [SW-1:0]             lw_addr,
	output logic [HW-1:0]             lw_data,
	output logic                      kw_en,
	output logic [SW-1:0]             kw_addr,
	output logic [bll_pkg::KEY_W-1:0] kw_data
);
	import bll_pkg::*;

	localparam logic [HW-1:0] HEAD_H = HW'(NODES);
	localparam logic [HW-1:0] TAIL_H = HW'(NODES + 1);
	localparam logic [CW-1:0] FULL_C = CW'(NODES);
	localparam logic [SW-1:0] LAST_STEP = SW'(NODES - 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_ENQ2 = 5'd2;
	localparam logic [4:0] S_POP  = 5'd3;
	localparam logic [4:0] S_INS  = 5'd4;
	localparam logic [4:0] S_INS2 = 5'd5;
	localparam logic [4:0] S_DEL1 = 5'd6;
	localparam logic [4:0] S_DEL2 = 5'd7;
	localparam logic [4:0] S_MV1  = 5'd8;
	localparam logic [4:0] S_MV2  = 5'd9;
	localparam logic [4:0] S_MV3  = 5'd10;
	localparam logic [4:0] S_X1   = 5'd11;
	localparam logic [4:0] S_X2   = 5'd12;
	localparam logic [4:0] S_XA1  = 5'd13;
	localparam logic [4:0] S_XA2  = 5'd14;
	localparam logic [4:0] S_XA3  = 5'd15;
	localparam logic [4:0] S_XN1  = 5'd16;
	localparam logic [4:0] S_XN2  = 5'd17;
	localparam logic [4:0] S_XN3  = 5'd18;
	localparam logic [4:0] S_XN4  = 5'd19;
	localparam logic [4:0] S_XN5  = 5'd20;
	localparam logic [4:0] S_FIND = 5'd21;

	logic [4:0]       state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [HW-1:0]    a_q, b_q;
	logic [HW-1:0]    head_q, head_d, rear_q, rear_d;
	logic [CW-1:0]    count_q, count_d;
	logic [NODES-1:0] used_q, used_d;
	logic [HW-1:0]    r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
	logic [SW-1:0]    step_q, step_d;
	logic             out_valid_q;
	logic [ST_W-1:0]  status_q;
	logic [KEY_W-1:0] key_out_q;
	logic [HW-1:0]    node_out_q;
	logic [CW-1:0]    count_out_q;

	logic             out_load, out_free, full;
	logic [ST_W-1:0]  res_status;
	logic [KEY_W-1:0] res_key;
	logic [HW-1:0]    res_node;
	logic [SW-1:0]    fs;
	logic             sl_en;
	logic [HW-1:0]    sl_h, sl_v;
	logic [HW-1:0]    lv, lb;

	function automatic logic in_list(input logic [HW-1:0] h, input logic [NODES-1:0] u);
		logic r;
		r = (h == HEAD_H) || (h == TAIL_H) || ((h < HEAD_H) && u[h[SW-1:0]]);
		return r;
	endfunction

	function automatic logic [HW-1:0] link_val(input logic [HW-1:0] h,
			input logic [HW-1:0] hd, input logic [HW-1:0] rl);
		logic [HW-1:0] r;
		if (h == HEAD_H) begin
			r = hd;
		end else if (h > HEAD_H) begin
			r = TAIL_H;
		end else begin
			r = rl;
		end
		return r;
	endfunction

	always_comb begin
		fs = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				fs = SW'(i);
			end
		end
	end

	assign full     = (count_q == FULL_C);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		rear_d = rear_q;
		count_d = count_q;
		used_d = used_q;
		r0_d = r0_q;
		r1_d = r1_q;
		r2_d = r2_q;
		r3_d = r3_q;
		step_d = step_q;
		rd_addr = a_q[SW-1:0];
		lw_en = 1'b0;
		lw_addr = fs;
		lw_data = head_q;
		kw_en = 1'b0;
		kw_addr = fs;
		kw_data = key_q;
		out_load = 1'b0;
		res_status = ST_OK;
		res_key = '0;
		res_node = '0;
		sl_en = 1'b0;
		sl_h = a_q;
		sl_v = r0_q;
		lv = link_val(a_q, head_q, rd_link);
		lb = link_val(b_q, head_q, rd_link);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (out_free) begin
					case (cmd_q)
						CMD_PUSH, CMD_ENQUEUE: begin
							if (full) begin
								out_load = 1'b1;
								res_status = ST_FULL;
							end else begin
								kw_en = 1'b1;
								lw_en = 1'b1;
								used_d[fs] = 1'b1;
								count_d = count_q + 1'b1;
								if (cmd_q == CMD_PUSH || count_q == '0) begin
									lw_data = head_q;
									head_d = HW'(fs);
									if (count_q == '0) begin
										rear_d = HW'(fs);
									end
									out_load = 1'b1;
									res_node = HW'(fs);
								end else begin
									lw_data = TAIL_H;
									r0_d = HW'(fs);
									state_d = S_ENQ2;
								end
							end
						end
						CMD_POP: begin
							rd_addr = head_q[SW-1:0];
							if (count_q == '0 || head_q >= HEAD_H) begin
								out_load = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								state_d = S_POP;
							end
						end
						CMD_INSERT: begin
							if (full) begin
								out_load = 1'b1;
								res_status = ST_FULL;
							end else if (a_q == TAIL_H || !in_list(a_q, used_q)) begin
								out_load = 1'b1;
								res_status = ST_BAD;
							end else begin
								state_d = S_INS;
							end
						end
						CMD_DELETE: begin
							if (!in_list(a_q, used_q)) begin
								out_load = 1'b1;
								res_status = ST_BAD;
							end else begin
								state_d = S_DEL1;
							end
						end
						CMD_MOVE: begin
							if (!(a_q < HEAD_H && used_q[a_q[SW-1:0]]) || a_q == rear_q) begin
								out_load = 1'b1;
								res_status = ST_BAD;
							end else begin
								state_d = S_MV1;
							end
						end
						CMD_EXCHANGE: begin
							if (a_q == b_q || !in_list(a_q, used_q) || !in_list(b_q, used_q)
									|| a_q == TAIL_H || b_q == TAIL_H) begin
								out_load = 1'b1;
								res_status = ST_BAD;
							end else begin
								state_d = S_X1;
							end
						end
						CMD_FIND: begin
							rd_addr = head_q[SW-1:0];
							if (head_q >= HEAD_H) begin
								out_load = 1'b1;
								res_status = ST_NOTFOUND;
							end else begin
								r0_d = head_q;
								step_d = '0;
								state_d = S_FIND;
							end
						end
						CMD_CLEAR: begin
							used_d = '0;
							head_d = TAIL_H;
							count_d = '0;
							rear_d = '0;
							out_load = 1'b1;
						end
						default: begin
							out_load = 1'b1;
							res_status = ST_BAD;
						end
					endcase
				end
			end
			S_ENQ2: begin
				sl_en = 1'b1;
				sl_h = rear_q;
				sl_v = r0_q;
				rear_d = r0_q;
				out_load = 1'b1;
				res_node = r0_q;
			end
			S_POP: begin
				res_key = rd_key;
				head_d = rd_link;
				used_d[head_q[SW-1:0]] = 1'b0;
				count_d = count_q - 1'b1;
				if (count_q == CW'(1)) begin
					rear_d = '0;
				end
				out_load = 1'b1;
			end
			S_INS: begin
				lw_en = 1'b1;
				lw_data = lv;
				kw_en = 1'b1;
				used_d[fs] = 1'b1;
				count_d = count_q + 1'b1;
				if (count_q == '0 || rear_q == a_q) begin
					rear_d = HW'(fs);
				end
				r0_d = HW'(fs);
				if (a_q == HEAD_H) begin
					head_d = HW'(fs);
					out_load = 1'b1;
					res_node = HW'(fs);
				end else begin
					state_d = S_INS2;
				end
			end
			S_INS2: begin
				sl_en = 1'b1;
				sl_h = a_q;
				sl_v = r0_q;
				out_load = 1'b1;
				res_node = r0_q;
			end
			S_DEL1: begin
				r0_d = lv;
				rd_addr = lv[SW-1:0];
				if (lv >= HEAD_H) begin
					out_load = 1'b1;
					res_status = ST_BAD;
				end else begin
					state_d = S_DEL2;
				end
			end
			S_DEL2: begin
				sl_en = 1'b1;
				sl_h = a_q;
				sl_v = rd_link;
				used_d[r0_q[SW-1:0]] = 1'b0;
				count_d = count_q - 1'b1;
				if (count_q == CW'(1)) begin
					rear_d = '0;
				end else if (r0_q == rear_q) begin
					rear_d = a_q;
				end
				out_load = 1'b1;
				res_node = a_q;
			end
			S_MV1: begin
				r0_d = rd_link;
				rd_addr = rd_link[SW-1:0];
				if (rd_link >= HEAD_H) begin
					out_load = 1'b1;
					res_status = ST_BAD;
				end else begin
					state_d = S_MV2;
				end
			end
			S_MV2: begin
				r1_d = rd_link;
				lw_en = 1'b1;
				lw_addr = r0_q[SW-1:0];
				lw_data = head_q;
				head_d = r0_q;
				if (r0_q == rear_q) begin
					rear_d = a_q;
				end
				state_d = S_MV3;
			end
			S_MV3: begin
				lw_en = 1'b1;
				lw_addr = a_q[SW-1:0];
				lw_data = r1_q;
				out_load = 1'b1;
				res_node = r0_q;
			end
			S_X1: begin
				r0_d = lv;
				rd_addr = b_q[SW-1:0];
				state_d = S_X2;
			end
			S_X2: begin
				if (r0_q == TAIL_H || lb == TAIL_H) begin
					out_load = 1'b1;
					res_status = ST_BAD;
				end else if (r0_q == b_q || lb == a_q) begin
					if (r0_q == b_q) begin
						r1_d = a_q;
						r2_d = b_q;
						r3_d = lb;
					end else begin
						r1_d = b_q;
						r2_d = a_q;
						r3_d = r0_q;
					end
					rd_addr = (r0_q == b_q) ? lb[SW-1:0] : r0_q[SW-1:0];
					state_d = S_XA1;
				end else begin
					r1_d = lb;
					rd_addr = lb[SW-1:0];
					state_d = S_XN1;
				end
			end
			S_XA1: begin
				r0_d = link_val(r3_q, head_q, rd_link);
				if (r3_q == rear_q) begin
					rear_d = r2_q;
				end
				sl_en = 1'b1;
				sl_h = r1_q;
				sl_v = r3_q;
				state_d = S_XA2;
			end
			S_XA2: begin
				sl_en = 1'b1;
				sl_h = r2_q;
				sl_v = r0_q;
				state_d = S_XA3;
			end
			S_XA3: begin
				sl_en = 1'b1;
				sl_h = r3_q;
				sl_v = r2_q;
				out_load = 1'b1;
				res_node = a_q;
			end
			S_XN1: begin
				r2_d = link_val(r1_q, head_q, rd_link);
				rd_addr = r0_q[SW-1:0];
				state_d = S_XN2;
			end
			S_XN2: begin
				r3_d = link_val(r0_q, head_q, rd_link);
				if (r0_q == rear_q) begin
					rear_d = r1_q;
				end else if (r1_q == rear_q) begin
					rear_d = r0_q;
				end
				sl_en = 1'b1;
				sl_h = a_q;
				sl_v = r1_q;
				state_d = S_XN3;
			end
			S_XN3: begin
				sl_en = 1'b1;
				sl_h = r1_q;
				sl_v = r3_q;
				state_d = S_XN4;
			end
			S_XN4: begin
				sl_en = 1'b1;
				sl_h = b_q;
				sl_v = r0_q;
				state_d = S_XN5;
			end
			S_XN5: begin
				sl_en = 1'b1;
				sl_h = r0_q;
				sl_v = r2_q;
				out_load = 1'b1;
				res_node = a_q;
			end
			S_FIND: begin
				rd_addr = rd_link[SW-1:0];
				if (rd_key == key_q) begin
					out_load = 1'b1;
					res_node = r0_q;
				end else if (step_q == LAST_STEP || rd_link >= HEAD_H) begin
					out_load = 1'b1;
					res_status = ST_NOTFOUND;
				end else begin
					r0_d = rd_link;
					step_d = step_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (sl_en) begin
			if (sl_h == HEAD_H) begin
				head_d = sl_v;
			end else if (sl_h < HEAD_H) begin
				lw_en = 1'b1;
				lw_addr = sl_h[SW-1:0];
				lw_data = sl_v;
			end
		end
		if (out_load) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= TAIL_H;
			rear_q <= '0;
			count_q <= '0;
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			rear_q <= rear_d;
			count_q <= count_d;
			used_q <= used_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd;
			key_q <= key_in;
			a_q <= node_a;
			b_q <= node_b;
		end
		r0_q <= r0_d;
		r1_q <= r1_d;
		r2_q <= r2_d;
		r3_q <= r3_d;
		step_q <= step_d;
		if (out_load) begin
			status_q <= res_status;
			key_out_q <= res_key;
			node_out_q <= res_node;
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign node_out  = node_out_q;
	assign count     = count_out_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C) else $error("node count above capacity");
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(used_q)) else $error("count differs from used slots");
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == TAIL_H) else $error("empty list head not at tail");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result loaded over a pending result");
`endif

endmodule
